### sv/prap_pkg.sv
// Shared types, constants and functions for the point rotator about a pivot.
package prap_pkg;

    // Default values for the top-level parameters.
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int COORD_BITS_DEF   = 11;
    localparam int CORDIC_STEPS_DEF = 16;

    // Fixed widths of the ports.
    localparam int OUT_BITS      = 14;
    localparam int STEP_BITS     = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // CORDIC datapath: 30 fractional bits plus headroom for the gain and sign.
    localparam int CORD_W    = 34;
    localparam int GAIN_Q30  = 652032874;
    localparam int Q15_HALF  = 16384;
    localparam int Q15_MAX   = 32767;
    localparam int Q15_MIN   = -32768;
    localparam int Q15_SHIFT = 15;

    // Register reset values.
    localparam int RST_PIVOT_X    = 320;
    localparam int RST_PIVOT_Y    = 240;
    localparam int RST_START_X    = 200;
    localparam int RST_START_Y    = 200;
    localparam int RST_ANGLE_STEP = 522;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PIVOT_X    = 3'd0,
        REG_PIVOT_Y    = 3'd1,
        REG_START_X    = 3'd2,
        REG_START_Y    = 3'd3,
        REG_ANGLE_STEP = 3'd4
    } t_cfg_reg;

    // Cosine and sine in Q1.15.
    typedef struct packed {
        logic signed [15:0] cos_q15;
        logic signed [15:0] sin_q15;
    } t_sincos;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic [31:0] atan_turn32(input logic [4:0] idx);
        case (idx)
            5'd0:    atan_turn32 = 32'h2000_0000;
            5'd1:    atan_turn32 = 32'h12E4_051D;
            5'd2:    atan_turn32 = 32'h09FB_385B;
            5'd3:    atan_turn32 = 32'h0511_11D4;
            5'd4:    atan_turn32 = 32'h028B_0D43;
            5'd5:    atan_turn32 = 32'h0145_D7E1;
            5'd6:    atan_turn32 = 32'h00A2_F61E;
            5'd7:    atan_turn32 = 32'h0051_7C55;
            5'd8:    atan_turn32 = 32'h0028_BE53;
            5'd9:    atan_turn32 = 32'h0014_5F2F;
            5'd10:   atan_turn32 = 32'h000A_2F98;
            5'd11:   atan_turn32 = 32'h0005_17CC;
            5'd12:   atan_turn32 = 32'h0002_8BE6;
            5'd13:   atan_turn32 = 32'h0001_45F3;
            5'd14:   atan_turn32 = 32'h0000_A2FA;
            5'd15:   atan_turn32 = 32'h0000_517D;
            5'd16:   atan_turn32 = 32'h0000_28BE;
            5'd17:   atan_turn32 = 32'h0000_145F;
            5'd18:   atan_turn32 = 32'h0000_0A30;
            5'd19:   atan_turn32 = 32'h0000_0518;
            5'd20:   atan_turn32 = 32'h0000_028C;
            5'd21:   atan_turn32 = 32'h0000_0146;
            5'd22:   atan_turn32 = 32'h0000_00A3;
            5'd23:   atan_turn32 = 32'h0000_0051;
            default: atan_turn32 = 32'h0000_0000;
        endcase
    endfunction

    // Round half up to Q1.15 and saturate.
    function automatic logic signed [15:0] to_q15(input logic signed [CORD_W-1:0] v);
        logic signed [CORD_W-1:0] r;
        r = (v + CORD_W'(Q15_HALF)) >>> Q15_SHIFT;
        if (r > CORD_W'(Q15_MAX)) begin
            to_q15 = 16'(Q15_MAX);
        end else if (r < CORD_W'(Q15_MIN)) begin
            to_q15 = 16'(Q15_MIN);
        end else begin
            to_q15 = r[15:0];
        end
    endfunction

endpackage

### sv/prap_cordic.sv
// Iterative rotation-mode CORDIC giving Q1.15 cosine and sine of a phase.
module prap_cordic import prap_pkg::*; #(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ANGLE_BITS-1:0] i_phase,
    output logic                  o_done,
    output t_sincos               o_sincos
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CORDIC_STEPS - 1);

    logic                     r_busy, r_fin, r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [1:0]               r_quad;
    logic signed [CORD_W-1:0] r_x, r_y, r_z;
    t_sincos                  r_sincos;

    logic [31:0]              angle32, residue;
    logic [1:0]               quad;
    logic signed [CORD_W-1:0] z0, xs, ys, atan_v;
    logic signed [CORD_W-1:0] n_x, n_y, n_z;
    logic signed [CORD_W-1:0] cos_raw, sin_raw;

    // Fold the angle into one quadrant centred on zero.
    always_comb begin
        angle32 = 32'(i_phase) << (32 - ANGLE_BITS);
        quad    = angle32[31:30] + {1'b0, angle32[29]};
        residue = angle32 - {quad, 30'b0};
        z0      = CORD_W'(signed'(residue));
    end

    // One micro-rotation per cycle through a shared add/shift datapath.
    always_comb begin
        xs     = r_x >>> r_cnt;
        ys     = r_y >>> r_cnt;
        atan_v = signed'({2'b00, atan_turn32(5'(r_cnt))});
        if (!r_z[CORD_W-1]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - atan_v;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + atan_v;
        end
    end

    always_comb begin
        unique case (r_quad)
            2'd0: begin cos_raw = r_x;  sin_raw = r_y;  end
            2'd1: begin cos_raw = -r_y; sin_raw = r_x;  end
            2'd2: begin cos_raw = -r_x; sin_raw = -r_y; end
            2'd3: begin cos_raw = r_y;  sin_raw = -r_x; end
            default: begin cos_raw = r_x; sin_raw = r_y; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORD_W'(GAIN_Q30);
            r_y    <= '0;
            r_z    <= z0;
            r_quad <= quad;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
        if (r_fin) begin
            r_sincos.cos_q15 <= to_q15(cos_raw);
            r_sincos.sin_q15 <= to_q15(sin_raw);
        end
    end

    assign o_done   = r_done;
    assign o_sincos = r_sincos;

endmodule

### sv/prap_mul.sv
// Shared multiplier that forms the four truncated products and sums them onto the pivot.
module prap_mul import prap_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  t_sincos                    i_sincos,
    input  logic [COORD_BITS-1:0]      i_pivot_x,
    input  logic [COORD_BITS-1:0]      i_pivot_y,
    input  logic [COORD_BITS-1:0]      i_start_x,
    input  logic [COORD_BITS-1:0]      i_start_y,
    output logic                       o_done,
    output logic signed [OUT_BITS-1:0] o_rx,
    output logic signed [OUT_BITS-1:0] o_ry
);

    localparam int DW    = COORD_BITS + 1;
    localparam int PW    = DW + 16;
    localparam int ACC_W = (COORD_BITS + 3 > OUT_BITS) ? COORD_BITS + 3 : OUT_BITS;

    logic                    r_busy, r_pvalid, r_done;
    logic [1:0]              r_k, r_pk;
    logic signed [DW-1:0]    r_dx, r_dy;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACC_W-1:0] r_acc_x, r_acc_y;

    logic signed [DW-1:0]    op_a;
    logic signed [15:0]      op_b;
    logic signed [PW-1:0]    prod, bias, adj;
    logic signed [ACC_W-1:0] term;

    // Product order: dx*cos, dy*sin, dx*sin, dy*cos.
    always_comb begin
        case (r_k)
            2'd0:    begin op_a = r_dx; op_b = i_sincos.cos_q15; end
            2'd1:    begin op_a = r_dy; op_b = i_sincos.sin_q15; end
            2'd2:    begin op_a = r_dx; op_b = i_sincos.sin_q15; end
            default: begin op_a = r_dy; op_b = i_sincos.cos_q15; end
        endcase
        prod = op_a * op_b;
    end

    // Divide by 2^15 truncating toward zero.
    always_comb begin
        bias = r_prod[PW-1] ? PW'(Q15_MAX) : '0;
        adj  = r_prod + bias;
        term = ACC_W'(adj >>> Q15_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pvalid <= 1'b0;
            r_done   <= 1'b0;
            r_k      <= '0;
        end else begin
            r_done   <= r_pvalid && (r_pk == 2'd3);
            r_pvalid <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 1'b1;
                if (r_k == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dx    <= signed'({1'b0, i_start_x}) - signed'({1'b0, i_pivot_x});
            r_dy    <= signed'({1'b0, i_start_y}) - signed'({1'b0, i_pivot_y});
            r_acc_x <= ACC_W'(i_pivot_x);
            r_acc_y <= ACC_W'(i_pivot_y);
        end else if (r_pvalid) begin
            case (r_pk)
                2'd0:    r_acc_x <= r_acc_x + term;
                2'd1:    r_acc_x <= r_acc_x - term;
                2'd2:    r_acc_y <= r_acc_y + term;
                default: r_acc_y <= r_acc_y + term;
            endcase
        end
        if (r_busy) begin
            r_prod <= prod;
            r_pk   <= r_k;
        end
    end

    assign o_done = r_done;
    assign o_rx   = r_acc_x[OUT_BITS-1:0];
    assign o_ry   = r_acc_y[OUT_BITS-1:0];

endmodule

### sv/point_rotator_about_pivot_top.sv
// A request passes from acceptance through the CORDIC iteration loop, one micro-rotation per
// cycle, and then through the shared multiplier to the result register. One request is
// handled at a time; the next is accepted the cycle after the result has moved into the
// output register.
// Reset (synchronous, active low) clears the phase to zero, loads the register defaults,
// and empties the output register.
module point_rotator_about_pivot_top import prap_pkg::*; #(
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_hold,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [OUT_BITS-1:0] o_rotated_x,
    output logic signed [OUT_BITS-1:0] o_rotated_y,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   i_cfg_data
);

    // The sequencer walks a request through the CORDIC, then the shared
    // multiplier, then hands the result to the output register.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CORDIC = 4'b0010,
        S_MUL    = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [COORD_BITS-1:0]      r_pivot_x, r_pivot_y, r_start_x, r_start_y;
    logic [STEP_BITS-1:0]       r_step;
    logic [ANGLE_BITS-1:0]      r_phase, n_phase;
    logic                       r_out_valid;
    logic signed [OUT_BITS-1:0] r_out_x, r_out_y;

    logic                       in_fire, out_fire, load_out;
    logic                       cordic_done, mul_done;
    t_sincos                    sincos;
    logic signed [OUT_BITS-1:0] mul_rx, mul_ry;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    // The finished result moves out once the output register is free or being emptied.
    assign load_out = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // The phase wraps modulo 2^ANGLE_BITS; a held request keeps the phase as it is.
    assign n_phase = i_hold ? r_phase : r_phase + ANGLE_BITS'(r_step);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_fire)     n_state = S_CORDIC;
            S_CORDIC: if (cordic_done) n_state = S_MUL;
            S_MUL:    if (mul_done)    n_state = S_OUT;
            S_OUT:    if (load_out)    n_state = S_IDLE;
            default:                   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_phase <= n_phase;
            end
            if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_x <= mul_rx;
            r_out_y <= mul_ry;
        end
    end

    // Configuration registers. Writes are expected only while the block is idle,
    // so the port is always ready. Indexes beyond the list are ignored and bits
    // above a register's width are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pivot_x <= COORD_BITS'(RST_PIVOT_X);
            r_pivot_y <= COORD_BITS'(RST_PIVOT_Y);
            r_start_x <= COORD_BITS'(RST_START_X);
            r_start_y <= COORD_BITS'(RST_START_Y);
            r_step    <= STEP_BITS'(RST_ANGLE_STEP);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PIVOT_X:    r_pivot_x <= COORD_BITS'(i_cfg_data);
                REG_PIVOT_Y:    r_pivot_y <= COORD_BITS'(i_cfg_data);
                REG_START_X:    r_start_x <= COORD_BITS'(i_cfg_data);
                REG_START_Y:    r_start_y <= COORD_BITS'(i_cfg_data);
                REG_ANGLE_STEP: r_step    <= STEP_BITS'(i_cfg_data);
                default:        ;
            endcase
        end
    end

    // The CORDIC captures the updated phase in the acceptance cycle.
    prap_cordic #(
        .ANGLE_BITS  (ANGLE_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire),
        .i_phase (n_phase),
        .o_done  (cordic_done),
        .o_sincos(sincos)
    );

    // The multiplier starts as soon as cosine and sine are ready; the CORDIC
    // holds them until its next start.
    prap_mul #(
        .COORD_BITS(COORD_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cordic_done),
        .i_sincos (sincos),
        .i_pivot_x(r_pivot_x),
        .i_pivot_y(r_pivot_y),
        .i_start_x(r_start_x),
        .i_start_y(r_start_y),
        .o_done   (mul_done),
        .o_rx     (mul_rx),
        .o_ry     (mul_ry)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_rotated_x = r_out_x;
    assign o_rotated_y = r_out_y;

    // The sequencer state is always exactly one of its one-hot codes.
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    // The CORDIC reports completion only while the sequencer waits for it.
    a_cordic_done_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_done |-> (r_state == S_CORDIC))
        else $error("CORDIC done outside its phase");

    // The multiplier reports completion only while the sequencer waits for it.
    a_mul_done_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL))
        else $error("multiplier done outside its phase");

    // A held request leaves the phase untouched.
    a_hold_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_hold) |=> $stable(r_phase))
        else $error("phase moved on a held request");

endmodule
